@@ rtl/bpc_pkg.sv @@
`timescale 1ns / 1ps

package bpc_pkg;

   // Field and calibration word widths
   localparam int RAW_W     = 24;
   localparam int CAL_W     = 16;
   localparam int OUT_W     = 32;
   localparam int CSR_IDX_W = 3;

   // Calibration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SENS_COEFF       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_COEFF     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SENS_TEMPCO      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_TEMPCO    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_REF_TEMPERATURE  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_TEMP_SENSITIVITY = 3'd5;

   // Scale factors, as shift amounts
   localparam int REF_SHIFT     = 8;
   localparam int TEMP_SHIFT    = 23;
   localparam int OFF_SHIFT     = 16;
   localparam int OFF_TC_SHIFT  = 7;
   localparam int SENS_SHIFT    = 15;
   localparam int SENS_TC_SHIFT = 8;
   localparam int T2_SHIFT      = 31;
   localparam int PRESS_SHIFT   = 21;

   // Temperature thresholds in 0.01 C
   localparam int TEMP_BASE  = 2000;
   localparam int COLD_BASE  = 1500;
   localparam int COLD_DELTA = TEMP_BASE + COLD_BASE;

   // Internal widths
   localparam int DT_W      = RAW_W + 1;
   localparam int MUL_W     = DT_W + CAL_W + 1;
   localparam int SQ_W      = 2 * DT_W;
   localparam int Q_W       = MUL_W - TEMP_SHIFT;
   localparam int OFF_TC_W  = MUL_W - OFF_TC_SHIFT;
   localparam int SENS_TC_W = MUL_W - SENS_TC_SHIFT;
   localparam int T2_W      = 2 * RAW_W - T2_SHIFT;
   localparam int OFF_W     = 40;
   localparam int C_W       = Q_W + 1;
   localparam int SQ2_W     = 2 * Q_W;
   localparam int CORR_W    = SQ2_W + 4;
   localparam int TEMP_W    = 21;
   localparam int SPLIT     = OFF_W / 2;
   localparam int PP_LO_W   = RAW_W + SPLIT;
   localparam int PP_HI_W   = RAW_W + SPLIT;
   localparam int PROD_W    = RAW_W + OFF_W;
   localparam int Q1_W      = PROD_W - PRESS_SHIFT;
   localparam int DIFF_W    = Q1_W + 1;
   localparam int P_W       = DIFF_W - SENS_SHIFT;

   typedef struct packed {
      logic [CAL_W-1:0] sens_coeff;
      logic [CAL_W-1:0] offset_coeff;
      logic [CAL_W-1:0] sens_tempco;
      logic [CAL_W-1:0] offset_tempco;
      logic [CAL_W-1:0] ref_temperature;
      logic [CAL_W-1:0] temp_sensitivity;
   } cal_type;

   localparam cal_type CAL_RESET = '{
      sens_coeff:       16'd40127,
      offset_coeff:     16'd36924,
      sens_tempco:      16'd23317,
      offset_tempco:    16'd23282,
      ref_temperature:  16'd33464,
      temp_sensitivity: 16'd28312
   };

   // First-order results
   typedef struct packed {
      logic [RAW_W-1:0]        raw_pressure;
      logic signed [Q_W-1:0]   temp_delta;
      logic signed [OFF_W-1:0] off;
      logic signed [OFF_W-1:0] sens;
      logic [T2_W-1:0]         t2;
   } base_type;

   // Corrected temperature, offset and sensitivity
   typedef struct packed {
      logic [RAW_W-1:0]         raw_pressure;
      logic signed [TEMP_W-1:0] temp;
      logic signed [OFF_W-1:0]  off;
      logic signed [OFF_W-1:0]  sens;
   } comp_type;

endpackage

@@ rtl/bpc_front.sv @@
`timescale 1ns / 1ps

module bpc_front (
   input  logic                        clock,
   input  logic                        reset,
   input  bpc_pkg::cal_type            cal,
   input  logic                        in_valid,
   output logic                        in_stall,
   input  logic [bpc_pkg::RAW_W-1:0]   in_raw_pressure,
   input  logic [bpc_pkg::RAW_W-1:0]   in_raw_temperature,
   output logic                        out_valid,
   input  logic                        out_stall,
   output bpc_pkg::base_type           out_data
);
   import bpc_pkg::*;

   logic v1_ff, v2_ff, v3_ff;
   logic v1_in, v2_in, v3_in;
   logic rdy1, rdy2, rdy3;

   logic signed [DT_W-1:0]      dt_in, dt_ff;
   logic [RAW_W-1:0]            d1_s1_ff, d1_s2_ff;
   logic signed [MUL_W-1:0]     mt_in, mo_in, ms_in;
   logic signed [MUL_W-1:0]     mt_ff, mo_ff, ms_ff;
   logic signed [SQ_W-1:0]      msq_in;
   logic [T2_W-1:0]             t2_in, t2_ff;
   logic signed [MUL_W-1:0]     mt_adj, mo_adj, ms_adj;
   logic signed [OFF_TC_W-1:0]  off_tc;
   logic signed [SENS_TC_W-1:0] sens_tc;
   base_type                    base_in, base_ff;

   // Advance a stage when it is empty or the next one moves
   assign rdy3     = !v3_ff || !out_stall;
   assign rdy2     = !v2_ff || rdy3;
   assign rdy1     = !v1_ff || rdy2;
   assign in_stall = !rdy1;

   assign v1_in = rdy1 ? in_valid : v1_ff;
   assign v2_in = rdy2 ? v1_ff : v2_ff;
   assign v3_in = rdy3 ? v2_ff : v3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   // Stage 1: temperature difference against the reference
   assign dt_in = $signed({1'b0, in_raw_temperature})
                - $signed({1'b0, cal.ref_temperature, {REF_SHIFT{1'b0}}});

   // Stage 2: coefficient products and dT squared
   assign mt_in  = dt_ff * $signed({1'b0, cal.temp_sensitivity});
   assign mo_in  = dt_ff * $signed({1'b0, cal.offset_tempco});
   assign ms_in  = dt_ff * $signed({1'b0, cal.sens_tempco});
   assign msq_in = dt_ff * dt_ff;
   assign t2_in  = msq_in[T2_SHIFT+T2_W-1:T2_SHIFT];

   // Stage 3: scale with truncation toward zero, add base terms
   assign mt_adj = mt_ff + $signed({{(MUL_W-TEMP_SHIFT){1'b0}},
                                    {TEMP_SHIFT{mt_ff[MUL_W-1]}}});
   assign mo_adj = mo_ff + $signed({{(MUL_W-OFF_TC_SHIFT){1'b0}},
                                    {OFF_TC_SHIFT{mo_ff[MUL_W-1]}}});
   assign ms_adj = ms_ff + $signed({{(MUL_W-SENS_TC_SHIFT){1'b0}},
                                    {SENS_TC_SHIFT{ms_ff[MUL_W-1]}}});
   assign off_tc  = mo_adj[MUL_W-1:OFF_TC_SHIFT];
   assign sens_tc = ms_adj[MUL_W-1:SENS_TC_SHIFT];

   always_comb begin
      base_in.raw_pressure = d1_s2_ff;
      base_in.temp_delta   = mt_adj[MUL_W-1:TEMP_SHIFT];
      base_in.off  = $signed({{(OFF_W-CAL_W-OFF_SHIFT){1'b0}}, cal.offset_coeff,
                              {OFF_SHIFT{1'b0}}})
                   + $signed({{(OFF_W-OFF_TC_W){off_tc[OFF_TC_W-1]}}, off_tc});
      base_in.sens = $signed({{(OFF_W-CAL_W-SENS_SHIFT){1'b0}}, cal.sens_coeff,
                              {SENS_SHIFT{1'b0}}})
                   + $signed({{(OFF_W-SENS_TC_W){sens_tc[SENS_TC_W-1]}}, sens_tc});
      base_in.t2   = t2_ff;
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         dt_ff    <= dt_in;
         d1_s1_ff <= in_raw_pressure;
      end
      if (rdy2) begin
         mt_ff    <= mt_in;
         mo_ff    <= mo_in;
         ms_ff    <= ms_in;
         t2_ff    <= t2_in;
         d1_s2_ff <= d1_s1_ff;
      end
      if (rdy3) begin
         base_ff <= base_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_data  = base_ff;

endmodule

@@ rtl/bpc_corr.sv @@
`timescale 1ns / 1ps

module bpc_corr (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_stall,
   input  bpc_pkg::base_type in_data,
   output logic              out_valid,
   input  logic              out_stall,
   output bpc_pkg::comp_type out_data
);
   import bpc_pkg::*;

   logic v1_ff, v2_ff, v3_ff;
   logic v1_in, v2_in, v3_in;
   logic rdy1, rdy2, rdy3;

   logic signed [C_W-1:0]    cold_in;
   logic [SQ2_W-1:0]         wsq_in, wsq_ff, csq_in, csq_ff;
   logic                     warm_in, warm_ff, cold_flag_in, cold_ff;
   base_type                 base_s1_ff;
   logic [CORR_W-1:0]        wsq_x, csq_x, five_w, seven_c, eleven_c;
   logic [CORR_W-1:0]        off2_in, off2_ff, sens2_in, sens2_ff;
   logic signed [TEMP_W-1:0] temp_in, temp_s2_ff;
   logic signed [OFF_W-1:0]  off_s2_ff, sens_s2_ff;
   logic [RAW_W-1:0]         d1_s2_ff;
   comp_type                 comp_in, comp_ff;

   // Advance a stage when it is empty or the next one moves
   assign rdy3     = !v3_ff || !out_stall;
   assign rdy2     = !v2_ff || rdy3;
   assign rdy1     = !v1_ff || rdy2;
   assign in_stall = !rdy1;

   assign v1_in = rdy1 ? in_valid : v1_ff;
   assign v2_in = rdy2 ? v1_ff : v2_ff;
   assign v3_in = rdy3 ? v2_ff : v3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   // Stage 1: squares of the distance below 20 C and below -15 C
   assign cold_in      = $signed({in_data.temp_delta[Q_W-1], in_data.temp_delta})
                       + $signed(C_W'(COLD_DELTA));
   assign wsq_in       = in_data.temp_delta * in_data.temp_delta;
   assign csq_in       = cold_in * cold_in;
   assign warm_in      = in_data.temp_delta[Q_W-1];
   assign cold_flag_in = cold_in[C_W-1];

   // Stage 2: second-order offset and sensitivity terms, corrected temperature
   assign wsq_x    = CORR_W'(wsq_ff);
   assign csq_x    = CORR_W'(csq_ff);
   assign five_w   = (wsq_x << 2) + wsq_x;
   assign seven_c  = (csq_x << 3) - csq_x;
   assign eleven_c = (csq_x << 3) + (csq_x << 1) + csq_x;

   assign off2_in  = (warm_ff ? (five_w >> 1) : '0) + (cold_ff ? seven_c : '0);
   assign sens2_in = (warm_ff ? (five_w >> 2) : '0) + (cold_ff ? (eleven_c >> 1) : '0);

   // Subtract T2 only below 20 C
   assign temp_in = $signed({{(TEMP_W-Q_W){base_s1_ff.temp_delta[Q_W-1]}},
                             base_s1_ff.temp_delta})
                  + $signed(TEMP_W'(TEMP_BASE))
                  - $signed({{(TEMP_W-T2_W){1'b0}},
                             (warm_ff ? base_s1_ff.t2 : {T2_W{1'b0}})});

   // Stage 3: subtract the corrections
   always_comb begin
      comp_in.raw_pressure = d1_s2_ff;
      comp_in.temp         = temp_s2_ff;
      comp_in.off          = off_s2_ff - $signed(off2_ff[OFF_W-1:0]);
      comp_in.sens         = sens_s2_ff - $signed(sens2_ff[OFF_W-1:0]);
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         wsq_ff     <= wsq_in;
         csq_ff     <= csq_in;
         warm_ff    <= warm_in;
         cold_ff    <= cold_flag_in;
         base_s1_ff <= in_data;
      end
      if (rdy2) begin
         off2_ff    <= off2_in;
         sens2_ff   <= sens2_in;
         temp_s2_ff <= temp_in;
         off_s2_ff  <= base_s1_ff.off;
         sens_s2_ff <= base_s1_ff.sens;
         d1_s2_ff   <= base_s1_ff.raw_pressure;
      end
      if (rdy3) begin
         comp_ff <= comp_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_data  = comp_ff;

`ifndef SYNTHESIS
   // Above 20 C no correction is applied
   assert property (@(posedge clock) disable iff (reset)
      v1_ff && !warm_ff && rdy2 |=> off2_ff == '0 && sens2_ff == '0)
      else $error("bpc_corr: correction applied above 20 C");

   // The offset correction never falls below the sensitivity correction
   assert property (@(posedge clock) disable iff (reset)
      v1_ff && rdy2 |=> off2_ff >= sens2_ff)
      else $error("bpc_corr: offset correction below sensitivity correction");
`endif

endmodule

@@ rtl/bpc_press.sv @@
`timescale 1ns / 1ps

module bpc_press (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_stall,
   input  bpc_pkg::comp_type                 in_data,
   output logic                              out_valid,
   input  logic                              out_stall,
   output logic signed [bpc_pkg::OUT_W-1:0]  out_temperature_centi,
   output logic signed [bpc_pkg::OUT_W-1:0]  out_pressure_pa
);
   import bpc_pkg::*;

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic v1_in, v2_in, v3_in, v4_in, v5_in;
   logic rdy1, rdy2, rdy3, rdy4, rdy5;

   logic [PP_LO_W-1:0]         lo_in, lo_ff;
   logic signed [PP_HI_W-1:0]  hi_in, hi_ff;
   logic signed [PROD_W-1:0]   prod_in, prod_ff, prod_adj;
   logic signed [Q1_W-1:0]     q1_in, q1_ff;
   logic signed [DIFF_W-1:0]   diff_in, diff_ff, diff_adj;
   logic signed [P_W-1:0]      p_val;
   logic signed [OFF_W-1:0]    off_s1_ff, off_s2_ff, off_s3_ff;
   logic signed [TEMP_W-1:0]   temp_s1_ff, temp_s2_ff, temp_s3_ff, temp_s4_ff;
   logic signed [OUT_W-1:0]    temp_out_in, temp_out_ff, press_out_in, press_out_ff;

   // Advance a stage when it is empty or the next one moves
   assign rdy5     = !v5_ff || !out_stall;
   assign rdy4     = !v4_ff || rdy5;
   assign rdy3     = !v3_ff || rdy4;
   assign rdy2     = !v2_ff || rdy3;
   assign rdy1     = !v1_ff || rdy2;
   assign in_stall = !rdy1;

   assign v1_in = rdy1 ? in_valid : v1_ff;
   assign v2_in = rdy2 ? v1_ff : v2_ff;
   assign v3_in = rdy3 ? v2_ff : v3_ff;
   assign v4_in = rdy4 ? v3_ff : v4_ff;
   assign v5_in = rdy5 ? v4_ff : v5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
         v5_ff <= v5_in;
      end
   end

   // Stage 1: raw pressure times the low and high halves of the sensitivity
   assign lo_in = in_data.raw_pressure * in_data.sens[SPLIT-1:0];
   assign hi_in = $signed({1'b0, in_data.raw_pressure})
                * $signed(in_data.sens[OFF_W-1:SPLIT]);

   // Stage 2: combine the partial products
   assign prod_in = $signed({hi_ff, {SPLIT{1'b0}}})
                  + $signed({{(PROD_W-PP_LO_W){1'b0}}, lo_ff});

   // Stage 3: scale the product, truncating toward zero
   assign prod_adj = prod_ff + $signed({{(PROD_W-PRESS_SHIFT){1'b0}},
                                        {PRESS_SHIFT{prod_ff[PROD_W-1]}}});
   assign q1_in    = prod_adj[PROD_W-1:PRESS_SHIFT];

   // Stage 4: remove the offset
   assign diff_in = $signed({q1_ff[Q1_W-1], q1_ff})
                  - $signed({{(DIFF_W-OFF_W){off_s3_ff[OFF_W-1]}}, off_s3_ff});

   // Stage 5: final scale toward zero, widen both results
   assign diff_adj     = diff_ff + $signed({{(DIFF_W-SENS_SHIFT){1'b0}},
                                            {SENS_SHIFT{diff_ff[DIFF_W-1]}}});
   assign p_val        = diff_adj[DIFF_W-1:SENS_SHIFT];
   assign press_out_in = $signed({{(OUT_W-P_W){p_val[P_W-1]}}, p_val});
   assign temp_out_in  = $signed({{(OUT_W-TEMP_W){temp_s4_ff[TEMP_W-1]}}, temp_s4_ff});

   always_ff @(posedge clock) begin
      if (rdy1) begin
         lo_ff      <= lo_in;
         hi_ff      <= hi_in;
         off_s1_ff  <= in_data.off;
         temp_s1_ff <= in_data.temp;
      end
      if (rdy2) begin
         prod_ff    <= prod_in;
         off_s2_ff  <= off_s1_ff;
         temp_s2_ff <= temp_s1_ff;
      end
      if (rdy3) begin
         q1_ff      <= q1_in;
         off_s3_ff  <= off_s2_ff;
         temp_s3_ff <= temp_s2_ff;
      end
      if (rdy4) begin
         diff_ff    <= diff_in;
         temp_s4_ff <= temp_s3_ff;
      end
      if (rdy5) begin
         press_out_ff <= press_out_in;
         temp_out_ff  <= temp_out_in;
      end
   end

   assign out_valid             = v5_ff;
   assign out_temperature_centi = temp_out_ff;
   assign out_pressure_pa       = press_out_ff;

`ifndef SYNTHESIS
   // A held first stage keeps its request and partial products
   assert property (@(posedge clock) disable iff (reset)
      v1_ff && !rdy1 |=> v1_ff && $stable(lo_ff) && $stable(hi_ff))
      else $error("bpc_press: held stage changed");

   // A full middle stage that cannot advance keeps its product
   assert property (@(posedge clock) disable iff (reset)
      v2_ff && !rdy2 |=> v2_ff && $stable(prod_ff) && $stable(off_s2_ff))
      else $error("bpc_press: stalled product lost");
`endif

endmodule

@@ rtl/baro_pressure_compensation.sv @@
// Barometric pressure compensation with second-order temperature correction.
// Request channel: req_valid / req_stall carry one raw 24-bit pressure and
// one raw 24-bit temperature conversion. A request is taken at a clock edge
// with req_valid high and req_stall low.
// Response channel: rsp_valid / rsp_stall return the temperature in 0.01 C
// and the pressure in Pa, both 32-bit two's complement, in request order.
// Calibration: csr_write_en with csr_index 0..5 loads one of the six 16-bit
// factory words; other indexes are dropped. Write only while no request is
// in flight.
// A request passes through an 11-stage pipeline (dT, products, first-order
// terms, squares, corrections, corrected terms, partial products, sum,
// product scale, offset removal, final scale).
// One request per cycle is sustained while rsp_stall is low.
// The 64-bit pressure product is split into two 24x20 multiplies.
// When rsp_stall is high, the output holds and the pipeline fills its empty
// stages; req_stall rises only once every stage holds a request.
// Synchronous reset empties the pipeline and loads the default calibration.
`timescale 1ns / 1ps

module baro_pressure_compensation (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [bpc_pkg::RAW_W-1:0]           req_raw_pressure,
   input  logic [bpc_pkg::RAW_W-1:0]           req_raw_temperature,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [bpc_pkg::OUT_W-1:0]    rsp_temperature_centi,
   output logic signed [bpc_pkg::OUT_W-1:0]    rsp_pressure_pa,
   input  logic                                csr_write_en,
   input  logic [bpc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [bpc_pkg::CAL_W-1:0]           csr_wdata
);
   import bpc_pkg::*;

   cal_type  cal_in, cal_ff;
   logic     front_valid, front_stall, corr_valid, corr_stall;
   base_type front_data;
   comp_type corr_data;

   // Load calibration words; drop unknown indexes
   always_comb begin
      cal_in = cal_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_SENS_COEFF:       cal_in.sens_coeff       = csr_wdata;
            CSR_OFFSET_COEFF:     cal_in.offset_coeff     = csr_wdata;
            CSR_SENS_TEMPCO:      cal_in.sens_tempco      = csr_wdata;
            CSR_OFFSET_TEMPCO:    cal_in.offset_tempco    = csr_wdata;
            CSR_REF_TEMPERATURE:  cal_in.ref_temperature  = csr_wdata;
            CSR_TEMP_SENSITIVITY: cal_in.temp_sensitivity = csr_wdata;
            default:              cal_in                  = cal_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ff <= CAL_RESET;
      end else begin
         cal_ff <= cal_in;
      end
   end

   bpc_front u_front (
      .clock              (clock),
      .reset              (reset),
      .cal                (cal_ff),
      .in_valid           (req_valid),
      .in_stall           (req_stall),
      .in_raw_pressure    (req_raw_pressure),
      .in_raw_temperature (req_raw_temperature),
      .out_valid          (front_valid),
      .out_stall          (front_stall),
      .out_data           (front_data)
   );

   bpc_corr u_corr (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_stall  (front_stall),
      .in_data   (front_data),
      .out_valid (corr_valid),
      .out_stall (corr_stall),
      .out_data  (corr_data)
   );

   bpc_press u_press (
      .clock                 (clock),
      .reset                 (reset),
      .in_valid              (corr_valid),
      .in_stall              (corr_stall),
      .in_data               (corr_data),
      .out_valid             (rsp_valid),
      .out_stall             (rsp_stall),
      .out_temperature_centi (rsp_temperature_centi),
      .out_pressure_pa       (rsp_pressure_pa)
   );

endmodule

@@ test/baro_compensation_checker.sv @@
`timescale 1ns / 1ps

// Watches the request, response and calibration ports, predicts each reading
// from a local copy of the calibration words and compares in request order.
module baro_compensation_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_stall,
   input  logic [bpc_pkg::RAW_W-1:0]        req_raw_pressure,
   input  logic [bpc_pkg::RAW_W-1:0]        req_raw_temperature,
   input  logic                             rsp_valid,
   input  logic                             rsp_stall,
   input  logic signed [bpc_pkg::OUT_W-1:0] rsp_temperature_centi,
   input  logic signed [bpc_pkg::OUT_W-1:0] rsp_pressure_pa,
   input  logic                             csr_write_en,
   input  logic [bpc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bpc_pkg::CAL_W-1:0]        csr_wdata,
   output int                               fail_count,
   output int                               pending_count,
   output int                               warm_count,
   output int                               cool_count,
   output int                               cold_count
);
   import bpc_pkg::*;

   localparam longint REF_MUL     = longint'(1) << REF_SHIFT;
   localparam longint TEMP_DIV    = longint'(1) << TEMP_SHIFT;
   localparam longint OFF_MUL     = longint'(1) << OFF_SHIFT;
   localparam longint OFF_TC_DIV  = longint'(1) << OFF_TC_SHIFT;
   localparam longint SENS_MUL    = longint'(1) << SENS_SHIFT;
   localparam longint SENS_TC_DIV = longint'(1) << SENS_TC_SHIFT;
   localparam longint T2_DIV      = longint'(1) << T2_SHIFT;
   localparam longint PRESS_DIV   = longint'(1) << PRESS_SHIFT;

   // Second-order correction weights
   localparam longint COOL_MUL      = 5;
   localparam longint OFF2_COLD_MUL = 7;
   localparam longint SENS2_COLD_MUL = 11;

   // Temperature band of the first-order result
   typedef enum logic [1:0] {BAND_WARM, BAND_COOL, BAND_COLD} band_type;

   typedef struct packed {
      band_type                band;
      logic [RAW_W-1:0]        raw_pressure;
      logic [RAW_W-1:0]        raw_temperature;
      logic signed [OUT_W-1:0] temperature_centi;
      logic signed [OUT_W-1:0] pressure_pa;
   } reading_type;

   cal_type     cal_shadow;
   reading_type expected_readings[$];
   reading_type predicted;
   reading_type oldest;

   // Compute the compensated temperature and pressure for one sample pair.
   function automatic reading_type compensate_reading(input cal_type cal,
                                                      input logic [RAW_W-1:0] raw_p,
                                                      input logic [RAW_W-1:0] raw_t);
      longint c1, c2, c3, c4, c5, c6;
      longint d1, d2, dt, temp, off, sens, t2, off2, sens2, warm_gap, cold_gap, press;
      reading_type r;
      c1 = cal.sens_coeff;
      c2 = cal.offset_coeff;
      c3 = cal.sens_tempco;
      c4 = cal.offset_tempco;
      c5 = cal.ref_temperature;
      c6 = cal.temp_sensitivity;
      d1 = raw_p;
      d2 = raw_t;
      dt   = d2 - c5 * REF_MUL;
      temp = TEMP_BASE + (dt * c6) / TEMP_DIV;
      off  = c2 * OFF_MUL + (c4 * dt) / OFF_TC_DIV;
      sens = c1 * SENS_MUL + (c3 * dt) / SENS_TC_DIV;
      t2 = 0;
      off2 = 0;
      sens2 = 0;
      r.band = BAND_WARM;
      // below 20.00 C: square-law correction, stronger again below -15.00 C
      if (temp < TEMP_BASE) begin
         r.band = BAND_COOL;
         warm_gap = temp - TEMP_BASE;
         t2    = (dt * dt) / T2_DIV;
         off2  = (COOL_MUL * warm_gap * warm_gap) / 2;
         sens2 = (COOL_MUL * warm_gap * warm_gap) / 4;
         if (temp < -COLD_BASE) begin
            r.band = BAND_COLD;
            cold_gap = temp + COLD_BASE;
            off2  += OFF2_COLD_MUL * cold_gap * cold_gap;
            sens2 += (SENS2_COLD_MUL * cold_gap * cold_gap) / 2;
         end
      end
      temp -= t2;
      off  -= off2;
      sens -= sens2;
      press = ((d1 * sens) / PRESS_DIV - off) / SENS_MUL;
      r.raw_pressure      = raw_p;
      r.raw_temperature   = raw_t;
      r.temperature_centi = temp[OUT_W-1:0];
      r.pressure_pa       = press[OUT_W-1:0];
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t ns mismatch: %s", $time, msg);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      pending_count = 0;
      warm_count = 0;
      cool_count = 0;
      cold_count = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         cal_shadow = CAL_RESET;
         expected_readings.delete();
      end else begin
         // track calibration writes; other indexes are dropped
         if (csr_write_en) begin
            case (csr_index)
               CSR_SENS_COEFF:       cal_shadow.sens_coeff = csr_wdata;
               CSR_OFFSET_COEFF:     cal_shadow.offset_coeff = csr_wdata;
               CSR_SENS_TEMPCO:      cal_shadow.sens_tempco = csr_wdata;
               CSR_OFFSET_TEMPCO:    cal_shadow.offset_tempco = csr_wdata;
               CSR_REF_TEMPERATURE:  cal_shadow.ref_temperature = csr_wdata;
               CSR_TEMP_SENSITIVITY: cal_shadow.temp_sensitivity = csr_wdata;
               default: ;
            endcase
         end
         // predict each accepted request
         if (req_valid && !req_stall) begin
            predicted = compensate_reading(cal_shadow, req_raw_pressure, req_raw_temperature);
            expected_readings.push_back(predicted);
            case (predicted.band)
               BAND_WARM: warm_count++;
               BAND_COOL: cool_count++;
               default:   cold_count++;
            endcase
         end
         // compare each accepted response with the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (expected_readings.size() == 0) begin
               report_mismatch($sformatf("response %0d / %0d with no request outstanding",
                                         rsp_temperature_centi, rsp_pressure_pa));
            end else begin
               oldest = expected_readings.pop_front();
               if (rsp_temperature_centi !== oldest.temperature_centi)
                  report_mismatch($sformatf("temperature_centi %0d, expected %0d (D1 %0d D2 %0d)",
                                            rsp_temperature_centi, oldest.temperature_centi,
                                            oldest.raw_pressure, oldest.raw_temperature));
               if (rsp_pressure_pa !== oldest.pressure_pa)
                  report_mismatch($sformatf("pressure_pa %0d, expected %0d (D1 %0d D2 %0d)",
                                            rsp_pressure_pa, oldest.pressure_pa,
                                            oldest.raw_pressure, oldest.raw_temperature));
            end
         end
      end
      pending_count = expected_readings.size();
   end

endmodule

@@ test/tb_baro_pressure_compensation.sv @@
`timescale 1ns / 1ps

module tb_baro_pressure_compensation;
   import bpc_pkg::*;

   localparam int     PIPE_LATENCY = 11;
   localparam int     IDLE_LIMIT   = 2000;
   localparam int     RAW_TOP      = (1 << RAW_W) - 1;

   // Indexes past the last calibration word
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_FIRST = CSR_IDX_W'(CSR_TEMP_SENSITIVITY + 1);
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_LAST  = '1;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [RAW_W-1:0]        req_raw_pressure = '0;
   logic [RAW_W-1:0]        req_raw_temperature = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic signed [OUT_W-1:0] rsp_temperature_centi;
   logic signed [OUT_W-1:0] rsp_pressure_pa;
   logic                    csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [CAL_W-1:0]        csr_wdata = '0;

   int fail_count, pending_count, warm_count, cool_count, cold_count;
   int idle_cycles = 0;
   int sent_count = 0;
   int setting_count = 0;
   int burst_left = 0;
   int stall_left = 0;
   int quiet_left = 0;
   cal_type cal_now;

   // Temperature offsets from 20.00 C around both correction thresholds
   int directed_deltas[6] = '{0, -1, 1, -(COLD_DELTA - 1), -COLD_DELTA, -(COLD_DELTA + 1)};

   baro_pressure_compensation dut (.*);

   baro_compensation_checker compensation_check (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_raw_pressure      (req_raw_pressure),
      .req_raw_temperature   (req_raw_temperature),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_temperature_centi (rsp_temperature_centi),
      .rsp_pressure_pa       (rsp_pressure_pa),
      .csr_write_en          (csr_write_en),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata),
      .fail_count            (fail_count),
      .pending_count         (pending_count),
      .warm_count            (warm_count),
      .cool_count            (cool_count),
      .cold_count            (cold_count)
   );

   always #5 clock = ~clock;

   // Abort when neither channel moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no request or response moved for %0d cycles", IDLE_LIMIT);
         $display("baro_pressure_compensation verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Mostly short gaps, now and then a long one
   function automatic int gap_length();
      if ($urandom_range(0, 19) == 0)
         return $urandom_range(20, 60);
      return $urandom_range(1, 3);
   endfunction

   function automatic logic [CAL_W-1:0] pick_cal_word();
      case ($urandom_range(0, 9))
         0, 1:    return '0;
         2, 3:    return '1;
         default: return CAL_W'($urandom_range(0, 65535));
      endcase
   endfunction

   // Raw temperature whose first-order reading lands delta hundredths from 20.00 C
   function automatic logic [RAW_W-1:0] raw_temp_for(input cal_type cal, input int delta);
      longint span, gain, center, dt, raw;
      span   = (delta < 0) ? -delta : delta;
      gain   = cal.temp_sensitivity;
      center = cal.ref_temperature;
      center = center << REF_SHIFT;
      dt = 0;
      if (gain != 0)
         dt = (span * (longint'(1) << TEMP_SHIFT) + gain - 1) / gain;
      if (delta < 0)
         dt = -dt;
      raw = center + dt;
      if (raw < 0)
         raw = 0;
      if (raw > RAW_TOP)
         raw = RAW_TOP;
      return raw[RAW_W-1:0];
   endfunction

   // Present one request and hold it until taken
   task automatic send_reading(input logic [RAW_W-1:0] pressure,
                               input logic [RAW_W-1:0] temperature);
      @(negedge clock);
      req_valid <= 1'b1;
      req_raw_pressure <= pressure;
      req_raw_temperature <= temperature;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      sent_count++;
   endtask

   task automatic hold_off(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
   endtask

   // Stop sending and wait for every outstanding response
   task automatic drain_pipeline();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_count != 0)
         @(negedge clock);
   endtask

   task automatic write_cal(input logic [CSR_IDX_W-1:0] index, input logic [CAL_W-1:0] value);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_write_en <= 1'b0;
      case (index)
         CSR_SENS_COEFF:       cal_now.sens_coeff = value;
         CSR_OFFSET_COEFF:     cal_now.offset_coeff = value;
         CSR_SENS_TEMPCO:      cal_now.sens_tempco = value;
         CSR_OFFSET_TEMPCO:    cal_now.offset_tempco = value;
         CSR_REF_TEMPERATURE:  cal_now.ref_temperature = value;
         CSR_TEMP_SENSITIVITY: cal_now.temp_sensitivity = value;
         default: ;
      endcase
   endtask

   task automatic load_calibration(input cal_type cal);
      write_cal(CSR_SENS_COEFF, cal.sens_coeff);
      write_cal(CSR_OFFSET_COEFF, cal.offset_coeff);
      write_cal(CSR_SENS_TEMPCO, cal.sens_tempco);
      write_cal(CSR_OFFSET_TEMPCO, cal.offset_tempco);
      write_cal(CSR_REF_TEMPERATURE, cal.ref_temperature);
      write_cal(CSR_TEMP_SENSITIVITY, cal.temp_sensitivity);
      setting_count++;
   endtask

   // Random requests, weighted toward both correction thresholds
   task automatic run_random(input int count);
      logic [RAW_W-1:0] pressure, temperature;
      int               pick;
      for (int i = 0; i < count; i++) begin
         if (burst_left > 0) begin
            burst_left--;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 3)
               burst_left = $urandom_range(20, 80);
            else if (pick < 4)
               drain_pipeline();
            else if (pick < 35)
               hold_off(gap_length());
         end
         case ($urandom_range(0, 9))
            0:       pressure = '0;
            1:       pressure = '1;
            default: pressure = RAW_W'($urandom_range(0, RAW_TOP));
         endcase
         case ($urandom_range(0, 9))
            0:       temperature = $urandom_range(0, 1) ? '0 : '1;
            1, 2:    temperature = raw_temp_for(cal_now, int'($urandom_range(0, 8)) - 4);
            3, 4:    temperature = raw_temp_for(cal_now,
                                                int'($urandom_range(0, 8)) - COLD_DELTA - 4);
            5, 6:    temperature = raw_temp_for(cal_now, int'($urandom_range(0, 25000)) - 20000);
            default: temperature = RAW_W'($urandom_range(0, RAW_TOP));
         endcase
         send_reading(pressure, temperature);
      end
   endtask

   // Response side stalls: random gaps plus stall-free stretches
   initial begin
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
            if (quiet_left > 0)
               quiet_left--;
            else if ($urandom_range(0, 99) < 2)
               quiet_left = $urandom_range(40, 150);
            else if ($urandom_range(0, 99) < 30)
               stall_left = gap_length();
         end
      end
   end

   initial begin
      cal_type cal;
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      cal_now = CAL_RESET;
      setting_count = 1;

      // field extremes, bit patterns and both thresholds at reset calibration
      send_reading('0, '0);
      send_reading('1, '1);
      send_reading('1, '0);
      send_reading('0, '1);
      send_reading(24'hAAAAAA, 24'h555555);
      send_reading(24'h555555, 24'hAAAAAA);
      foreach (directed_deltas[i])
         send_reading(RAW_W'($urandom_range(0, RAW_TOP)),
                      raw_temp_for(cal_now, directed_deltas[i]));
      run_random(100);
      drain_pipeline();

      // all words at full scale; writes past the last index must be dropped
      cal = '1;
      load_calibration(cal);
      write_cal(CSR_UNUSED_FIRST, pick_cal_word());
      write_cal(CSR_UNUSED_LAST, 16'h0000);
      run_random(60);
      drain_pipeline();

      // all words cleared
      cal = '0;
      load_calibration(cal);
      run_random(40);
      drain_pipeline();

      // random calibration sets
      repeat (3) begin
         cal.sens_coeff       = pick_cal_word();
         cal.offset_coeff     = pick_cal_word();
         cal.sens_tempco      = pick_cal_word();
         cal.offset_tempco    = pick_cal_word();
         cal.ref_temperature  = pick_cal_word();
         cal.temp_sensitivity = pick_cal_word();
         load_calibration(cal);
         run_random(50);
         drain_pipeline();
      end

      // high reference with full gain: uniform raw temperatures fall deep in the cold band
      cal = CAL_RESET;
      cal.ref_temperature  = '1;
      cal.temp_sensitivity = '1;
      load_calibration(cal);
      run_random(40);
      drain_pipeline();

      // zero reference and zero sensitivity: warm band only
      cal.ref_temperature = '0;
      cal.sens_coeff      = '0;
      load_calibration(cal);
      run_random(30);
      drain_pipeline();

      repeat (PIPE_LATENCY + 4) @(negedge clock);

      $display("Run summary: %0d requests over %0d calibration settings, zero and full scale included.",
               sent_count, setting_count);
      $display("First-order bands: %0d at or above 20 C, %0d cool, %0d below -15 C.",
               warm_count, cool_count, cold_count);
      if (fail_count == 0 && pending_count == 0)
         $display("baro_pressure_compensation verification clean");
      else
         $display("baro_pressure_compensation verification failed");
      $finish;
   end

endmodule

@@ files.f @@
rtl/bpc_pkg.sv
rtl/bpc_front.sv
rtl/bpc_corr.sv
rtl/bpc_press.sv
rtl/baro_pressure_compensation.sv
test/baro_compensation_checker.sv
test/tb_baro_pressure_compensation.sv
